// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helpers for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   // sizes
   localparam int MAX_PAGES   = 16384;
   localparam int TOP_ORDER   = 10;
   localparam int NUM_ORDERS  = TOP_ORDER + 1;
   localparam int STORE_DEPTH = 2 * MAX_PAGES;
   localparam int PAGE_SHIFT  = 12;
   localparam int PAGE_W      = 14;
   localparam int SLOT_W      = 15;
   localparam int DEPTH_W     = 15;
   localparam int ORD_W       = 4;
   localparam int ADDR_W      = 48;
   localparam int TOTAL_W     = 15;

   // request modes
   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FAIL = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   // register indexes
   localparam logic CSR_BASE_ADDR   = 1'b0;
   localparam logic CSR_TOTAL_PAGES = 1'b1;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_CARVE,
      OP_FAIL,
      OP_FREE,
      OP_POP,
      OP_LATCH,
      OP_SPLIT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       order_bad;
      logic       found;
      logic       carve_done;
      logic       split_done;
   } dp_stat_type;

   // room of the stack for order k
   function automatic logic [DEPTH_W-1:0] stack_cap(input logic [ORD_W-1:0] k);
      return DEPTH_W'(MAX_PAGES >> k);
   endfunction

   // first slot of the stack for order k (stacks packed one after another)
   function automatic logic [SLOT_W-1:0] stack_base(input logic [ORD_W-1:0] k);
      return SLOT_W'(STORE_DEPTH - (STORE_DEPTH >> k));
   endfunction

endpackage

// ===== src/bpa_dpath.sv =====
// ----------------------------------------------------------------------------
// bpa_dpath
// Stack store, stack depth counters, configuration registers and result
// registers of the buddy page allocator, driven one operation per cycle.
// ----------------------------------------------------------------------------
module bpa_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  bpa_pkg::ctrl_cmd_type            cmd,
   output bpa_pkg::dp_stat_type             stat,
   input  logic [1:0]                       req_mode,
   input  logic [bpa_pkg::ORD_W-1:0]        req_order,
   input  logic [bpa_pkg::PAGE_W-1:0]       req_page_index,
   output logic [1:0]                       rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]       rsp_block_page,
   output logic [bpa_pkg::ADDR_W-1:0]       rsp_block_addr,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0]       csr_wdata
);
   import bpa_pkg::*;

   // stack store
   logic [PAGE_W-1:0]  store_mem [STORE_DEPTH];
   logic [PAGE_W-1:0]  rd_data_ff;
   logic [SLOT_W-1:0]  mem_addr;
   logic [PAGE_W-1:0]  mem_wdata;
   logic               mem_we;

   // control state
   logic [DEPTH_W-1:0] depth_ff [NUM_ORDERS];
   logic [DEPTH_W-1:0] depth_in [NUM_ORDERS];
   logic [ADDR_W-1:0]  base_addr_ff;
   logic [TOTAL_W-1:0] total_pages_ff;

   // payload
   logic [1:0]         mode_ff;
   logic [ORD_W-1:0]   order_ff;
   logic [PAGE_W-1:0]  pidx_ff;
   logic [ORD_W-1:0]   ord_ff, ord_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [TOTAL_W-1:0] remain_ff, remain_in;
   logic [TOTAL_W-1:0] carve_page_ff, carve_page_in;
   logic [1:0]         status_ff, status_in;
   logic [PAGE_W-1:0]  block_page_ff, block_page_in;
   logic [ADDR_W-1:0]  block_addr_ff, block_addr_in;

   // helpers
   logic               order_bad;
   logic               found;
   logic [ORD_W-1:0]   found_idx;
   logic [ORD_W-1:0]   carve_k;
   logic [ORD_W-1:0]   split_ord;
   logic               push_req;
   logic [ORD_W-1:0]   push_ord;
   logic [PAGE_W-1:0]  push_page;
   logic               push_full;

   assign order_bad = (order_ff > ORD_W'(TOP_ORDER));
   assign split_ord = ord_ff - ORD_W'(1);

   // lowest non-empty stack at or above the asked order
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
         if ((ORD_W'(i) >= order_ff) && (depth_ff[i] != '0)) begin
            found     = 1'b1;
            found_idx = ORD_W'(i);
         end
      end
   end

   // largest block left to carve, capped at the top order
   always_comb begin
      carve_k = '0;
      if (remain_ff >= (TOTAL_W'(1) << TOP_ORDER)) begin
         carve_k = ORD_W'(TOP_ORDER);
      end else begin
         for (int i = 0; i < TOP_ORDER; i++) begin
            if (remain_ff[i]) begin
               carve_k = ORD_W'(i);
            end
         end
      end
   end

   // push source select
   always_comb begin
      push_req  = 1'b0;
      push_ord  = '0;
      push_page = '0;
      case (cmd.op)
         OP_CARVE: begin
            push_req  = 1'b1;
            push_ord  = carve_k;
            push_page = carve_page_ff[PAGE_W-1:0];
         end
         OP_FREE: begin
            push_req  = !order_bad;
            push_ord  = order_bad ? '0 : order_ff;
            push_page = pidx_ff;
         end
         OP_SPLIT: begin
            push_req  = 1'b1;
            push_ord  = split_ord;
            push_page = page_ff + (PAGE_W'(1) << split_ord);
         end
         default: begin
            push_req  = 1'b0;
         end
      endcase
   end

   assign push_full = (depth_ff[push_ord] >= stack_cap(push_ord));
   assign mem_we    = push_req && !push_full;
   assign mem_wdata = push_page;

   // one store access per cycle: pop reads the top, push writes above it
   always_comb begin
      if (cmd.op == OP_POP) begin
         mem_addr = stack_base(found_idx) + SLOT_W'(depth_ff[found_idx] - DEPTH_W'(1));
      end else begin
         mem_addr = stack_base(push_ord) + SLOT_W'(depth_ff[push_ord]);
      end
   end

   // next values
   always_comb begin
      depth_in      = depth_ff;
      ord_in        = ord_ff;
      page_in       = page_ff;
      remain_in     = remain_ff;
      carve_page_in = carve_page_ff;
      status_in     = status_ff;
      block_page_in = block_page_ff;
      block_addr_in = block_addr_ff;
      if (mem_we) begin
         depth_in[push_ord] = depth_ff[push_ord] + DEPTH_W'(1);
      end
      case (cmd.op)
         OP_LOAD: begin
            status_in     = STAT_OK;
            block_page_in = '0;
            block_addr_in = '0;
         end
         OP_INIT: begin
            for (int i = 0; i < NUM_ORDERS; i++) begin
               depth_in[i] = '0;
            end
            remain_in     = (total_pages_ff > TOTAL_W'(MAX_PAGES)) ?
                            TOTAL_W'(MAX_PAGES) : total_pages_ff;
            carve_page_in = '0;
         end
         OP_CARVE: begin
            remain_in     = remain_ff - (TOTAL_W'(1) << carve_k);
            carve_page_in = carve_page_ff + (TOTAL_W'(1) << carve_k);
         end
         OP_FAIL: begin
            status_in = STAT_FAIL;
         end
         OP_FREE: begin
            if (order_bad) begin
               status_in = STAT_FAIL;
            end else if (push_full) begin
               status_in = STAT_FULL;
            end
         end
         OP_POP: begin
            depth_in[found_idx] = depth_ff[found_idx] - DEPTH_W'(1);
            ord_in              = found_idx;
         end
         OP_LATCH: begin
            page_in = rd_data_ff;
         end
         OP_SPLIT: begin
            ord_in = split_ord;
         end
         OP_FINISH: begin
            block_page_in = page_ff;
            block_addr_in = base_addr_ff + (ADDR_W'(page_ff) << PAGE_SHIFT);
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ORDERS; i++) begin
            depth_ff[i] <= '0;
         end
         base_addr_ff   <= '0;
         total_pages_ff <= TOTAL_W'(MAX_PAGES);
      end else begin
         depth_ff <= depth_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BASE_ADDR:   base_addr_ff   <= csr_wdata;
               CSR_TOTAL_PAGES: total_pages_ff <= csr_wdata[TOTAL_W-1:0];
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         mode_ff  <= req_mode;
         order_ff <= req_order;
         pidx_ff  <= req_page_index;
      end
      ord_ff        <= ord_in;
      page_ff       <= page_in;
      remain_ff     <= remain_in;
      carve_page_ff <= carve_page_in;
      status_ff     <= status_in;
      block_page_ff <= block_page_in;
      block_addr_ff <= block_addr_in;
   end

   // stack store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_addr];
   end

   // status to the controller
   assign stat.mode       = mode_ff;
   assign stat.order_bad  = order_bad;
   assign stat.found      = found;
   assign stat.carve_done = (remain_ff == '0);
   assign stat.split_done = (ord_ff == order_ff);

   assign csr_ready      = 1'b1;
   assign rsp_status     = status_ff;
   assign rsp_block_page = block_page_ff;
   assign rsp_block_addr = block_addr_ff;

endmodule

// ===== src/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: dispatches init, alloc and free and times the result.
// ----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output bpa_pkg::ctrl_cmd_type cmd,
   input  bpa_pkg::dp_stat_type  stat
);
   import bpa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CARVE,
      ST_READ,
      ST_SPLIT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      strobe_ff;

   // next state and operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.mode)
               MODE_INIT: begin
                  cmd.op   = OP_INIT;
                  state_in = ST_CARVE;
               end
               MODE_ALLOC: begin
                  if (stat.order_bad || !stat.found) begin
                     cmd.op   = OP_FAIL;
                     state_in = ST_RESP;
                  end else begin
                     cmd.op   = OP_POP;
                     state_in = ST_READ;
                  end
               end
               MODE_FREE: begin
                  cmd.op   = OP_FREE;
                  state_in = ST_RESP;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_CARVE: begin
            if (stat.carve_done) begin
               state_in = ST_RESP;
            end else begin
               cmd.op = OP_CARVE;
            end
         end
         ST_READ: begin
            cmd.op   = OP_LATCH;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (stat.split_done) begin
               cmd.op   = OP_FINISH;
               state_in = ST_RESP;
            end else begin
               cmd.op = OP_SPLIT;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != ST_IDLE);
         strobe_ff <= (state_in == ST_RESP);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== src/buddy_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy page allocator with one free stack per order and no coalescing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its result shows
// on the rsp_ ports for one cycle under rsp_strobe; the receiver cannot stall
// it. One request is worked on at a time, one stack store access per cycle.
// A free, a bad order or failed alloc, and the unused mode go from dispatch
// straight to the result; an alloc pops and reads a block, then splits it once
// per order between the found and the asked order (at most 10 splits); init
// clears the stacks, then carves the pages into blocks (at most 25 blocks).
// The next request can be taken the cycle after the strobe. The stack store
// is not cleared after reset; the block needs no clearing pass. Configuration
// writes are always ready and must only be made while busy is low.
module buddy_page_allocator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_mode,
   input  logic [bpa_pkg::ORD_W-1:0]  req_order,
   input  logic [bpa_pkg::PAGE_W-1:0] req_page_index,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0] rsp_block_page,
   output logic [bpa_pkg::ADDR_W-1:0] rsp_block_addr,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0] csr_wdata
);
   import bpa_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer
   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   // stacks and results
   bpa_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_mode),
      .req_order      (req_order),
      .req_page_index (req_page_index),
      .rsp_status     (rsp_status),
      .rsp_block_page (rsp_block_page),
      .rsp_block_addr (rsp_block_addr),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

endmodule

// ===== src/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic [1:0]                 rsp_status,
   input logic [bpa_pkg::PAGE_W-1:0] rsp_block_page,
   input logic [bpa_pkg::ADDR_W-1:0] rsp_block_addr
);
   import bpa_pkg::*;

   // a taken request makes the block busy
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken but busy not raised");

   // a result only appears while a request is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe without a request in flight");

   // the result ends the request
   a_strobe_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("block still busy after its result");

   // failed requests carry no block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != STAT_OK) |->
         (rsp_block_page == '0) && (rsp_block_addr == '0))
      else $error("failed request returned a block");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_block_page (rsp_block_page),
   .rsp_block_addr (rsp_block_addr)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy page allocator. Requests are driven on
// the falling edge; results are checked against a model of the per-order
// free stacks, or the table for typed rows. The run opens with the directed
// table, then goes through register settings, each with an init and a mix
// of allocs, frees of held blocks, bad orders and stray requests.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   localparam logic [1:0]  MODE_UNUSED    = 2'd3;
   localparam int          PHASE_COUNT    = 7;
   localparam int          PHASE_REQUESTS = 133;
   localparam int          DIRECTED_ROWS  = 22;
   localparam int          DRAIN_CYCLES   = 40;
   localparam int unsigned CYCLE_LIMIT    = 500000;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] page;
      logic [ADDR_W-1:0] addr;
   } alloc_result_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [ORD_W-1:0]  ord;
   } held_block_type;

   typedef struct {
      logic [1:0]        mode;
      logic [ORD_W-1:0]  ord;
      logic [PAGE_W-1:0] pidx;
      bit                typed;
      logic [1:0]        status;
      logic [PAGE_W-1:0] page;
      logic [ADDR_W-1:0] addr;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_mode;
   logic [ORD_W-1:0]    req_order;
   logic [PAGE_W-1:0]   req_page_index;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic [PAGE_W-1:0]   rsp_block_page;
   logic [ADDR_W-1:0]   rsp_block_addr;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [ADDR_W-1:0]   csr_wdata;

   // model of the free stacks and registers
   logic [PAGE_W-1:0]   model_store [STORE_DEPTH];
   int unsigned         model_depth [NUM_ORDERS];
   logic [ADDR_W-1:0]   model_base;
   logic [TOTAL_W-1:0]  model_total;

   alloc_result_type    expected_results [$];
   held_block_type      held_blocks [$];
   directed_row_type    directed_rows [DIRECTED_ROWS];

   int unsigned         error_count;
   int unsigned         result_count;
   int unsigned         cycle_count;
   int unsigned         n_requests, n_inits, n_granted, n_refused;
   int unsigned         n_stacked, n_dropped, n_bad_order, n_settings;

   buddy_page_allocator_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_order      (req_order),
      .req_page_index (req_page_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_block_page (rsp_block_page),
      .rsp_block_addr (rsp_block_addr),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
   end

   // room and first slot of the stack for one order
   function automatic int unsigned order_room(input int unsigned k);
      return MAX_PAGES >> k;
   endfunction

   function automatic int unsigned order_first_slot(input int unsigned k);
      int unsigned sum;
      sum = 0;
      for (int unsigned j = 0; j < k; j++)
         sum += order_room(j);
      return sum;
   endfunction

   // push a block onto an order's stack, zero when that stack is full
   function automatic bit push_free(input int unsigned k, input int unsigned page);
      if (model_depth[k] >= order_room(k))
         return 1'b0;
      model_store[order_first_slot(k) + model_depth[k]] = page[PAGE_W-1:0];
      model_depth[k]++;
      return 1'b1;
   endfunction

   // outcome of one request, updating the modelled stacks
   function automatic alloc_result_type predict_allocation(input logic [1:0] mode,
                                                           input logic [ORD_W-1:0] ord,
                                                           input logic [PAGE_W-1:0] pidx);
      alloc_result_type r;
      int unsigned      n, k, page, i, slot;
      r = '0;
      case (mode)
         MODE_INIT: begin
            for (k = 0; k < NUM_ORDERS; k++)
               model_depth[k] = 0;
            n = (model_total > MAX_PAGES) ? MAX_PAGES : model_total;
            page = 0;
            // carve into the largest blocks, capped at the top order
            while (n > 0) begin
               k = 0;
               while (k < 31 && (32'd1 << (k + 1)) <= n)
                  k++;
               if (k > TOP_ORDER)
                  k = TOP_ORDER;
               void'(push_free(k, page));
               n -= 32'd1 << k;
               page += 32'd1 << k;
            end
         end
         MODE_ALLOC: begin
            if (ord > TOP_ORDER) begin
               r.status = STAT_FAIL;
            end else begin
               i = ord;
               while (i <= TOP_ORDER && model_depth[i] == 0)
                  i++;
               if (i > TOP_ORDER) begin
                  r.status = STAT_FAIL;
               end else begin
                  model_depth[i]--;
                  slot = order_first_slot(i) + model_depth[i];
                  page = model_store[slot];
                  // split down, leaving the upper buddy at each order
                  while (i > ord) begin
                     i--;
                     void'(push_free(i, page + (32'd1 << i)));
                  end
                  r.page = page[PAGE_W-1:0];
                  r.addr = model_base + (ADDR_W'(page[PAGE_W-1:0]) << PAGE_SHIFT);
               end
            end
         end
         MODE_FREE: begin
            if (ord > TOP_ORDER)
               r.status = STAT_FAIL;
            else if (!push_free(ord, pidx))
               r.status = STAT_FULL;
         end
         default: ;
      endcase
      return r;
   endfunction

   // drive one request after a gap, called and returning on a falling edge
   task automatic issue_request(input logic [1:0] mode, input logic [ORD_W-1:0] ord,
                                input logic [PAGE_W-1:0] pidx, input bit typed,
                                input alloc_result_type typed_res, input int unsigned gap);
      alloc_result_type want;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          = 1'b1;
      req_mode       = mode;
      req_order      = ord;
      req_page_index = pidx;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      want = predict_allocation(mode, ord, pidx);
      n_requests++;
      if (mode == MODE_INIT) begin
         n_inits++;
         held_blocks.delete();
      end
      if ((mode == MODE_ALLOC || mode == MODE_FREE) && ord > TOP_ORDER)
         n_bad_order++;
      else if (mode == MODE_ALLOC && want.status == STAT_OK) begin
         n_granted++;
         held_blocks.push_back('{want.page, ord});
      end else if (mode == MODE_ALLOC)
         n_refused++;
      else if (mode == MODE_FREE && want.status == STAT_OK)
         n_stacked++;
      else if (mode == MODE_FREE)
         n_dropped++;
      expected_results.push_back(typed ? typed_res : want);
      @(negedge clock);
   endtask

   // hold off until every outstanding request has answered
   task automatic wait_idle();
      start = 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   // write both registers while idle
   task automatic apply_settings(input logic [ADDR_W-1:0] base,
                                 input logic [TOTAL_W-1:0] total,
                                 input logic [ADDR_W-TOTAL_W-1:0] junk);
      csr_valid = 1'b1;
      csr_index = CSR_BASE_ADDR;
      csr_wdata = base;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      model_base = base;
      @(negedge clock);
      csr_index = CSR_TOTAL_PAGES;
      csr_wdata = {junk, total};
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      model_total = total;
      @(negedge clock);
      csr_valid = 1'b0;
      n_settings++;
   endtask

   // result checker
   always @(posedge clock) begin : result_check
      alloc_result_type want;
      if (!reset && rsp_strobe) begin
         result_count++;
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: status %0d page %0d addr %h",
                        rsp_status, rsp_block_page, rsp_block_addr);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_block_page !== want.page ||
                rsp_block_addr !== want.addr) begin
               error_count++;
               if (error_count <= 10)
                  $display("result %0d: exp status %0d page %0d addr %h, got %0d %0d %h",
                           result_count, want.status, want.page, want.addr,
                           rsp_status, rsp_block_page, rsp_block_addr);
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      alloc_result_type  typed_res;
      logic [1:0]        mode;
      logic [ORD_W-1:0]  ord;
      logic [PAGE_W-1:0] pidx;
      logic [63:0]       rnd;
      logic [ADDR_W-1:0] base;
      logic [TOTAL_W-1:0] total;
      int unsigned       pick, idx, gap;
      bit                no_idle;

      start          = 1'b0;
      req_mode       = MODE_INIT;
      req_order      = '0;
      req_page_index = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_BASE_ADDR;
      csr_wdata      = '0;
      error_count    = 0;
      result_count   = 0;
      n_requests = 0; n_inits = 0; n_granted = 0; n_refused = 0;
      n_stacked = 0; n_dropped = 0; n_bad_order = 0; n_settings = 0;
      for (int k = 0; k < NUM_ORDERS; k++)
         model_depth[k] = 0;
      model_base  = '0;
      model_total = TOTAL_W'(MAX_PAGES);

      // typed rows hold values readable straight from the reset state
      directed_rows = '{
         '{MODE_ALLOC,  4'd0,  14'd0,     1'b1, STAT_FAIL, 14'd0,     48'd0},
         '{MODE_FREE,   4'd11, 14'd0,     1'b1, STAT_FAIL, 14'd0,     48'd0},
         '{MODE_ALLOC,  4'd15, 14'd0,     1'b1, STAT_FAIL, 14'd0,     48'd0},
         '{MODE_FREE,   4'd15, 14'd16383, 1'b1, STAT_FAIL, 14'd0,     48'd0},
         '{MODE_UNUSED, 4'd15, 14'd16383, 1'b1, STAT_OK,   14'd0,     48'd0},
         '{MODE_INIT,   4'd0,  14'd0,     1'b1, STAT_OK,   14'd0,     48'd0},
         '{MODE_ALLOC,  4'd10, 14'd0,     1'b1, STAT_OK,   14'd15360, 48'h0000_03C0_0000},
         '{MODE_ALLOC,  4'd0,  14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_ALLOC,  4'd0,  14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_ALLOC,  4'd3,  14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_FREE,   4'd0,  14'd16383, 1'b1, STAT_OK,   14'd0,     48'd0},
         '{MODE_ALLOC,  4'd0,  14'd0,     1'b1, STAT_OK,   14'd16383, 48'h0000_03FF_F000},
         '{MODE_FREE,   4'd5,  14'd3,     1'b1, STAT_OK,   14'd0,     48'd0},
         '{MODE_ALLOC,  4'd5,  14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_FREE,   4'd10, 14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_FREE,   4'd10, 14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_FREE,   4'd10, 14'd1024,  1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_FREE,   4'd10, 14'd2048,  1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_ALLOC,  4'd10, 14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_FREE,   4'd9,  14'd16383, 1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_ALLOC,  4'd1,  14'd0,     1'b0, STAT_OK,   14'd0,     48'd0},
         '{MODE_INIT,   4'd0,  14'd0,     1'b1, STAT_OK,   14'd0,     48'd0}
      };

      // synchronous reset
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed requests on the reset settings
      foreach (directed_rows[r]) begin
         typed_res = '{directed_rows[r].status, directed_rows[r].page,
                       directed_rows[r].addr};
         issue_request(directed_rows[r].mode, directed_rows[r].ord,
                       directed_rows[r].pidx, directed_rows[r].typed, typed_res,
                       $urandom_range(0, 7));
      end

      // random requests under a series of settings
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         rnd = {$urandom, $urandom};
         case (p)
            0: begin base = 48'hFFFF_FFFF_F000; total = 15'd16383; end
            1: begin base = '0; total = '0; end
            2: begin base = {rnd[47:12], 12'h000}; total = 15'h7FFF; end
            3: begin base = 48'hFFFF_FFFF_FFFF; total = 15'd1; end
            4: begin base = rnd[47:0]; total = TOTAL_W'($urandom_range(1, MAX_PAGES)); end
            5: begin base = {rnd[47:12], 12'h000}; total = TOTAL_W'(MAX_PAGES); end
            default: begin base = rnd[47:0]; total = TOTAL_W'($urandom_range(2, 100)); end
         endcase
         rnd = {$urandom, $urandom};
         apply_settings(base, total, rnd[ADDR_W-TOTAL_W-1:0]);
         no_idle = (p == 2 || p == 5);
         issue_request(MODE_INIT, ORD_W'($urandom), PAGE_W'($urandom), 1'b0, '0, 0);

         for (int n = 1; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(0, 59) == 0)
               wait_idle();
            pick = $urandom_range(0, 99);
            ord  = ORD_W'($urandom);
            pidx = PAGE_W'($urandom);
            if (pick < 4) begin
               mode = MODE_INIT;
            end else if (pick < 8) begin
               mode = MODE_UNUSED;
            end else if (pick < 13) begin
               // order beyond the top one
               mode = ($urandom_range(0, 1) != 0) ? MODE_ALLOC : MODE_FREE;
               ord  = ORD_W'($urandom_range(TOP_ORDER + 1, 15));
            end else if (pick < 55) begin
               mode = MODE_ALLOC;
               if ($urandom_range(0, 9) < 6)
                  ord = ORD_W'($urandom_range(0, 3));
               else
                  ord = ORD_W'($urandom_range(0, TOP_ORDER));
            end else if (pick < 85 && held_blocks.size() != 0) begin
               // hand back a held block, now and then keeping it for a double free
               mode = MODE_FREE;
               idx  = $urandom_range(0, held_blocks.size() - 1);
               pidx = held_blocks[idx].page;
               ord  = held_blocks[idx].ord;
               if ($urandom_range(0, 9) != 0)
                  held_blocks.delete(idx);
            end else begin
               // free of an arbitrary, possibly misaligned block
               mode = MODE_FREE;
               ord  = ORD_W'($urandom_range(0, TOP_ORDER));
            end
            gap = no_idle ? 0 : $urandom_range(0, 7);
            issue_request(mode, ord, pidx, 1'b0, '0, gap);
         end
      end

      // drain and settle
      start = 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         error_count += expected_results.size();
         $display("%0d expected results never arrived", expected_results.size());
      end

      $display("covered %0d requests over %0d register settings: %0d inits, %0d bad orders",
               n_requests, n_settings, n_inits, n_bad_order);
      $display("allocs %0d granted / %0d refused, frees %0d stacked / %0d dropped, %0d errors",
               n_granted, n_refused, n_stacked, n_dropped, error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== buddy_page_allocator_top.f =====
src/bpa_pkg.sv
src/bpa_dpath.sv
src/bpa_ctrl.sv
src/buddy_page_allocator_top.sv
src/bpa_checker.sv
tb/sv/tb_top.sv
